// ----- rtl/core/ute_pkg.sv -----
// shared types, constants and helpers of the utf-8 and entity text decoder
`timescale 1ns / 1ps
package ute_pkg;

  localparam int unsigned ENTITY_SCAN_LIMIT_DEF = 6;
  localparam int unsigned CP_W = 21;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  localparam logic [CP_W-1:0] CP_SPACE = 21'd32;
  localparam logic [CP_W-1:0] CP_AMP   = 21'd38;
  localparam logic [CP_W-1:0] CP_NBSP  = 21'd160;
  localparam logic [CP_W-1:0] CP_LT    = 21'd60;
  localparam logic [CP_W-1:0] CP_GT    = 21'd62;
  localparam logic [CP_W-1:0] CP_QUOT  = 21'd34;
  localparam logic [CP_W-1:0] CP_APOS  = 21'd39;

  // entity names, first character in the top byte
  localparam logic [31:0] NAME_NBSP = 32'h6E62_7370;
  localparam logic [15:0] NAME_LT   = 16'h6C74;
  localparam logic [15:0] NAME_GT   = 16'h6774;
  localparam logic [23:0] NAME_AMP  = 24'h616D70;
  localparam logic [31:0] NAME_QUOT = 32'h7175_6F74;
  localparam logic [31:0] NAME_APOS = 32'h6170_6F73;

  typedef enum logic [1:0] {
    CASE_NONE    = 2'd0,
    CASE_UPPER   = 2'd1,
    CASE_LOWER   = 2'd2,
    CASE_CAPITAL = 2'd3
  } ute_case_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } ute_state_e;

  // one byte waiting in the replay queue
  typedef struct packed {
    logic [7:0] data;
    logic       ws;
    logic       last;
  } ute_qitem_t;

  // one buffered entity name byte
  typedef struct packed {
    logic       ws;
    logic [7:0] data;
  } ute_ent_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
    logic cfg_wr;
  } ute_cmd_t;

  typedef struct packed {
    logic run_done;
    logic pend_valid;
    logic out_busy;
  } ute_stat_t;

  // ascii letter case change, everything else passes
  function automatic logic [CP_W-1:0] case_xform(input logic [CP_W-1:0] cp,
                                                 input logic ws,
                                                 input logic [1:0] mode);
    logic up;
    logic [CP_W-1:0] res;
    up  = (mode == CASE_UPPER) || ((mode == CASE_CAPITAL) && ws);
    res = cp;
    if (up && (cp inside {[21'd97:21'd122]})) begin
      res = cp - 21'd32;
    end else if ((mode == CASE_LOWER) && (cp inside {[21'd65:21'd90]})) begin
      res = cp + 21'd32;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/ute_if.sv -----
// request channels of the text decoder: byte input, code point output, config write
`timescale 1ns / 1ps
interface ute_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       word_start;
  logic       end_of_text;

  modport source (output valid, output data_byte, output word_start, output end_of_text,
                  input ready);
  modport sink (input valid, input data_byte, input word_start, input end_of_text,
                output ready);
endinterface

interface ute_out_if;
  logic                       valid;
  logic                       ready;
  logic [ute_pkg::CP_W-1:0]   code_point;
  logic                       run_last;

  modport source (output valid, output code_point, output run_last, input ready);
  modport sink (input valid, input code_point, input run_last, output ready);
endinterface

interface ute_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] text_case_mode;

  modport source (output valid, output text_case_mode, input ready);
  modport sink (input valid, input text_case_mode, output ready);
endinterface

// ----- rtl/core/ute_ctrl.sv -----
// sequencer of the text decoder: accept, process queue, flush last result
`timescale 1ns / 1ps
module ute_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  ute_pkg::ute_stat_t stat_i,
  output ute_pkg::ute_cmd_t  cmd_o
);
  import ute_pkg::*;

  ute_state_e state_q, state_d;
  logic       can_step;

  assign can_step = !(stat_i.pend_valid && stat_i.out_busy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (can_step && stat_i.run_done) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cfg_ready_o  = 1'b1;
    cmd_o        = '0;
    cmd_o.cfg_wr = cfg_valid_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = can_step;
      end
      ST_FLUSH: begin
        cmd_o.flush = !stat_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/ute_datapath.sv -----
// decoder datapath: replay queue, utf-8 and entity state, result staging
`timescale 1ns / 1ps
module ute_datapath #(
  parameter int unsigned ScanLimit = ute_pkg::ENTITY_SCAN_LIMIT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ute_pkg::ute_cmd_t        cmd_i,
  output ute_pkg::ute_stat_t       stat_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_ws_i,
  input  logic                     in_last_i,
  input  logic [1:0]               cfg_mode_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [ute_pkg::CP_W-1:0] out_cp_o,
  output logic                     out_last_o
);
  import ute_pkg::*;

  localparam int unsigned Q   = ScanLimit + 2;
  localparam int unsigned QW  = $clog2(Q + 1);
  localparam int unsigned QIW = $clog2(Q);
  localparam int unsigned CW  = $clog2(ScanLimit + 1);
  localparam int unsigned IW  = $clog2(ScanLimit);

  ute_qitem_t q_q [Q];
  ute_qitem_t new_q [Q];
  ute_qitem_t popped [Q];
  ute_qitem_t rep [Q];
  logic [QW-1:0] qlen_q, qlen_d, qlen_pop, room, nrep, n_ins;

  ute_ent_t ebuf_q [ScanLimit];
  ute_ent_t eff [ScanLimit];
  ute_ent_t new_ent;
  logic [CW-1:0] ecnt_q, ecnt_d, cnt_eff;
  logic          eact_q, eact_d;

  logic [CP_W-1:0] acc_q, acc_d, acc_n;
  logic [1:0]      rem_q, rem_d;
  logic            lws_q, lws_d;
  logic [1:0]      mode_q;

  logic            pend_v_q;
  logic [CP_W-1:0] pend_cp_q;
  logic [QW-1:0]   rcnt_q;
  logic            out_v_q, out_last_q;
  logic [CP_W-1:0] out_cp_q;

  ute_qitem_t      item;
  logic            res_v, keep_res, fail, fail_tail, buf_wr, lead, move_out;
  logic [CP_W-1:0] res_cp, match_cp;
  logic [7:0]      b0, b1, b2, b3;

  assign item    = q_q[0];
  assign new_ent = '{ws: item.ws, data: item.data};
  assign b0 = ebuf_q[0].data;
  assign b1 = ebuf_q[1].data;
  assign b2 = ebuf_q[2].data;
  assign b3 = ebuf_q[3].data;

  // exact name match against the known entities
  always_comb begin
    match_cp = '0;
    if (ecnt_q == CW'(4) && {b0, b1, b2, b3} == NAME_NBSP) match_cp = CP_NBSP;
    else if (ecnt_q == CW'(2) && {b0, b1} == NAME_LT) match_cp = CP_LT;
    else if (ecnt_q == CW'(2) && {b0, b1} == NAME_GT) match_cp = CP_GT;
    else if (ecnt_q == CW'(3) && {b0, b1, b2} == NAME_AMP) match_cp = CP_AMP;
    else if (ecnt_q == CW'(4) && {b0, b1, b2, b3} == NAME_QUOT) match_cp = CP_QUOT;
    else if (ecnt_q == CW'(4) && {b0, b1, b2, b3} == NAME_APOS) match_cp = CP_APOS;
  end

  // decode of the byte at the queue head
  always_comb begin
    eact_d    = eact_q;
    ecnt_d    = ecnt_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    lws_d     = lws_q;
    res_v     = 1'b0;
    res_cp    = '0;
    fail      = 1'b0;
    fail_tail = 1'b0;
    buf_wr    = 1'b0;
    lead      = 1'b0;
    acc_n     = {acc_q[CP_W-7:0], item.data[5:0]};
    if (eact_q) begin
      if (item.data == CHAR_SEMI) begin
        if (match_cp != '0) begin
          res_v  = 1'b1;
          res_cp = case_xform(match_cp, lws_q, mode_q);
          eact_d = 1'b0;
          ecnt_d = '0;
        end else begin
          fail      = 1'b1;
          fail_tail = 1'b1;
        end
      end else if (ecnt_q < CW'(ScanLimit)) begin
        buf_wr = 1'b1;
        ecnt_d = ecnt_q + CW'(1);
        fail   = item.last;
      end else begin
        fail      = 1'b1;
        fail_tail = 1'b1;
      end
    end else if (rem_q != 2'd0) begin
      acc_d = acc_n;
      rem_d = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        res_v  = 1'b1;
        res_cp = case_xform(acc_n, lws_q, mode_q);
      end else if (item.last) begin
        res_v  = 1'b1;
        res_cp = CP_SPACE;
        rem_d  = 2'd0;
        acc_d  = '0;
      end
    end else if (item.data == CHAR_AMP) begin
      eact_d = 1'b1;
      ecnt_d = '0;
      lws_d  = item.ws;
      fail   = item.last;
    end else if (!item.data[7]) begin
      res_v  = 1'b1;
      res_cp = case_xform({{(CP_W-8){1'b0}}, item.data}, item.ws, mode_q);
    end else if ((item.data & 8'hF8) == 8'hF0) begin
      lead  = 1'b1;
      acc_d = {{(CP_W-3){1'b0}}, item.data[2:0]};
      rem_d = 2'd3;
    end else if ((item.data & 8'hF0) == 8'hE0) begin
      lead  = 1'b1;
      acc_d = {{(CP_W-4){1'b0}}, item.data[3:0]};
      rem_d = 2'd2;
    end else if ((item.data & 8'hE0) == 8'hC0) begin
      lead  = 1'b1;
      acc_d = {{(CP_W-5){1'b0}}, item.data[4:0]};
      rem_d = 2'd1;
    end else begin
      res_v  = 1'b1;
      res_cp = CP_SPACE;
    end
    if (lead) begin
      lws_d = item.ws;
      if (item.last) begin
        res_v  = 1'b1;
        res_cp = CP_SPACE;
        rem_d  = 2'd0;
        acc_d  = '0;
      end
    end
    if (fail) begin
      res_v  = 1'b1;
      res_cp = case_xform(CP_AMP, lws_d, mode_q);
      eact_d = 1'b0;
      ecnt_d = '0;
    end
  end

  // failed scan: buffered bytes plus the ending byte go back in front of the queue
  always_comb begin
    cnt_eff = buf_wr ? ecnt_q + CW'(1) : ecnt_q;
    for (int i = 0; i < ScanLimit; i++) begin
      eff[i] = ebuf_q[i];
      if (buf_wr && ecnt_q == CW'(i)) eff[i] = new_ent;
    end
    for (int j = 0; j < Q; j++) begin
      rep[j] = '0;
    end
    for (int j = 0; j < ScanLimit; j++) begin
      if (CW'(j) < cnt_eff) begin
        rep[j] = '{data: eff[j].data, ws: eff[j].ws,
                   last: !fail_tail && (CW'(j) == cnt_eff - CW'(1))};
      end
    end
    for (int j = 0; j < Q; j++) begin
      if (fail_tail && QW'(j) == QW'(cnt_eff)) rep[j] = item;
    end
    for (int k = 0; k < Q - 1; k++) begin
      popped[k] = q_q[k+1];
    end
    popped[Q-1] = '0;
    qlen_pop = qlen_q - QW'(1);
    room     = QW'(Q) - qlen_pop;
    nrep     = QW'(cnt_eff) + QW'(fail_tail);
    n_ins    = fail ? ((nrep < room) ? nrep : room) : '0;
    for (int j = 0; j < Q; j++) begin
      if (QW'(j) < n_ins) begin
        new_q[j] = rep[j];
      end else if (QW'(j) - n_ins < qlen_pop) begin
        new_q[j] = popped[QIW'(QW'(j) - n_ins)];
      end else begin
        new_q[j] = '0;
      end
    end
    qlen_d = qlen_pop + n_ins;
  end

  assign keep_res = res_v && (rcnt_q < QW'(Q));
  assign move_out = (cmd_i.step && keep_res && pend_v_q) || (cmd_i.flush && pend_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q   <= '0;
      eact_q   <= 1'b0;
      ecnt_q   <= '0;
      acc_q    <= '0;
      rem_q    <= 2'd0;
      lws_q    <= 1'b0;
      mode_q   <= CASE_NONE;
      pend_v_q <= 1'b0;
      rcnt_q   <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) mode_q <= cfg_mode_i;
      if (cmd_i.load) begin
        qlen_q <= QW'(1);
        rcnt_q <= '0;
      end
      if (cmd_i.step) begin
        qlen_q <= qlen_d;
        eact_q <= eact_d;
        ecnt_q <= ecnt_d;
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        lws_q  <= lws_d;
        if (keep_res) begin
          rcnt_q   <= rcnt_q + QW'(1);
          pend_v_q <= 1'b1;
        end
      end
      if (cmd_i.flush) pend_v_q <= 1'b0;
      if (move_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) q_q[0] <= '{data: in_byte_i, ws: in_ws_i, last: in_last_i};
    if (cmd_i.step) begin
      q_q <= new_q;
      if (buf_wr) ebuf_q[ecnt_q[IW-1:0]] <= new_ent;
      if (keep_res) pend_cp_q <= res_cp;
    end
    if (move_out) begin
      out_cp_q   <= pend_cp_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign stat_o.run_done   = (qlen_d == '0);
  assign stat_o.pend_valid = pend_v_q;
  assign stat_o.out_busy   = out_v_q && !out_ready_i;

  assign out_valid_o = out_v_q;
  assign out_cp_o    = out_cp_q;
  assign out_last_o  = out_last_q;

  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= QW'(Q))
    else $error("replay queue overfilled");

  a_utf8_vs_entity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(eact_q && (rem_q != 2'd0)))
    else $error("entity scan open inside a utf-8 sequence");

  a_move_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && keep_res && pend_v_q) |-> !(out_v_q && !out_ready_i))
    else $error("staged result pushed over a waiting output");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !pend_v_q)
    else $error("staged result left after flush");

endmodule

// ----- rtl/core/utf8_entity_text_decoder.sv -----
// top level of the utf-8 and html entity text decoder
`timescale 1ns / 1ps
// sequence: a byte request passes accept, decode and flush before the next is taken,
//   plus a decode step for every byte replayed after a failed entity scan, and output
//   back-pressure stalls it; the last result of a byte goes from the staged register
//   to the output in the flush state, after the decode steps of the byte and its replays
// reset: rst_ni low clears all decoder, queue and output control state at once;
//   text_case_mode returns to 0 and the entity buffer stays undefined until written
module utf8_entity_text_decoder #(
  parameter int unsigned ENTITY_SCAN_LIMIT = ute_pkg::ENTITY_SCAN_LIMIT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ute_in_if.sink    in_if,
  ute_out_if.source out_if,
  ute_cfg_if.sink   cfg_if
);
  import ute_pkg::*;

  ute_cmd_t  cmd;
  ute_stat_t stat;

  // sequencer: takes a byte request only when the previous byte is fully done,
  // then steps the queue one byte a cycle while the output is not stalled, until it drains
  ute_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_o (cfg_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: replay queue, utf-8 accumulator, entity buffer, one staged result
  // so the last one of a byte can be flagged, and the output register
  ute_datapath #(
    .ScanLimit (ENTITY_SCAN_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_byte_i   (in_if.data_byte),
    .in_ws_i     (in_if.word_start),
    .in_last_i   (in_if.end_of_text),
    .cfg_mode_i  (cfg_if.text_case_mode),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_cp_o    (out_if.code_point),
    .out_last_o  (out_if.run_last)
  );

endmodule
